/* rtl/dmc_pkg.sv */
package dmc_pkg;

    localparam int unsigned WORD_W          = 32;
    localparam int unsigned SHIFT_W         = 5;
    localparam int unsigned LOG_W           = 6;
    localparam int unsigned STEPS_PER_STAGE = 4;

    localparam logic MODE_UNSIGNED = 1'b0;
    localparam logic MODE_SIGNED   = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] divisor;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0]  multiplier;
        logic               pre_shift;
        logic [SHIFT_W-1:0] post_shift;
        logic               divisor_negative;
        logic               zero_divisor;
    } out_word_t;

    // shift and flag fields that ride alongside the divider
    typedef struct packed {
        logic               pre_shift;
        logic [SHIFT_W-1:0] post_shift;
        logic               divisor_negative;
        logic               zero_divisor;
    } side_t;

    // divider stage contents: partial remainder, quotient so far, denominator
    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] quo;
        logic [WORD_W-1:0] den;
        side_t             side;
    } div_word_t;

endpackage

/* rtl/dmc_prep.sv */
module dmc_prep
    import dmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  in_word_t  in_word,
    output logic      out_valid,
    output div_word_t out_word
);

    // stage 1: magnitude and magnitude minus one
    logic              s1_valid_reg;
    logic              s1_mode_reg;
    logic              s1_neg_reg;
    logic              s1_zero_reg;
    logic [WORD_W-1:0] s1_den_reg;
    logic [WORD_W-1:0] s1_dm1_reg;

    logic              neg_next;
    logic [WORD_W-1:0] den_next;
    logic [WORD_W-1:0] dm1_next;

    always_comb
    begin
        neg_next = (in_word.mode == MODE_SIGNED) && in_word.divisor[WORD_W-1];
        if (neg_next)
        begin
            den_next = ~in_word.divisor + {{(WORD_W-1){1'b0}}, 1'b1};
            dm1_next = ~in_word.divisor;          // -d - 1
        end
        else
        begin
            den_next = in_word.divisor;
            dm1_next = in_word.divisor - {{(WORD_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg <= in_word.mode;
        s1_neg_reg  <= neg_next;
        s1_zero_reg <= (in_word.divisor == '0);
        s1_den_reg  <= den_next;
        s1_dm1_reg  <= dm1_next;
    end

    // stage 2: ceil(log2) via leading zeros, numerator high word, shifts
    function automatic logic [LOG_W-1:0] lead_zeros(input logic [WORD_W-1:0] x);
        logic [LOG_W-1:0] n;
        n = LOG_W'(WORD_W);
        for (int i = 0; i < WORD_W; i++)
        begin
            if (x[i])
                n = LOG_W'(WORD_W - 1 - i);
        end
        return n;
    endfunction

    logic [LOG_W-1:0]  l_val;
    logic [WORD_W:0]   pow_l;
    logic [WORD_W:0]   diff_u;
    logic [WORD_W-1:0] high_next;
    side_t             side_next;
    div_word_t         s2_word_reg;
    logic              s2_valid_reg;

    always_comb
    begin
        l_val  = LOG_W'(WORD_W) - lead_zeros(s1_dm1_reg);
        pow_l  = (WORD_W+1)'(1) << l_val;
        diff_u = pow_l - {1'b0, s1_den_reg};

        if (s1_mode_reg == MODE_UNSIGNED)
            high_next = diff_u[WORD_W-1:0];
        else if (l_val == '0)
            high_next = '0;                       // magnitude one
        else
            high_next = WORD_W'(1) << SHIFT_W'(l_val - LOG_W'(1));

        side_next.pre_shift        = (s1_mode_reg == MODE_UNSIGNED) && (l_val != '0);
        side_next.post_shift       = (l_val == '0) ? '0 : SHIFT_W'(l_val - LOG_W'(1));
        side_next.divisor_negative = s1_neg_reg;
        side_next.zero_divisor     = 1'b0;

        if (s1_zero_reg)
        begin
            high_next                  = '0;
            side_next.pre_shift        = 1'b0;
            side_next.post_shift       = '0;
            side_next.divisor_negative = 1'b0;
            side_next.zero_divisor     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_word_reg.rem  <= high_next;
        s2_word_reg.quo  <= '0;
        s2_word_reg.den  <= s1_den_reg;
        s2_word_reg.side <= side_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_word  = s2_word_reg;

endmodule

/* rtl/dmc_div_stage.sv */
module dmc_div_stage
    import dmc_pkg::*;
#(
    parameter int unsigned STEPS = STEPS_PER_STAGE
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  div_word_t in_word,
    output logic      out_valid,
    output div_word_t out_word
);

    // restoring division, STEPS quotient bits per stage
    div_word_t word_next;
    div_word_t word_reg;
    logic      valid_reg;

    always_comb
    begin
        logic [WORD_W:0] trial;
        word_next = in_word;
        for (int s = 0; s < STEPS; s++)
        begin
            trial = {word_next.rem, 1'b0};
            if (trial >= {1'b0, word_next.den})
            begin
                trial         = trial - {1'b0, word_next.den};
                word_next.quo = {word_next.quo[WORD_W-2:0], 1'b1};
            end
            else
            begin
                word_next.quo = {word_next.quo[WORD_W-2:0], 1'b0};
            end
            word_next.rem = trial[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* rtl/division_magic_constants_top.sv */
// A result strobes on done once the accepted word has passed prep stages 1 and 2, the divider
// stages and the output register.
// Throughput: one word per cycle while busy is low; the divider is fully pipelined,
// one stage per STEPS_PER_STAGE quotient bits, so back-to-back starts are all taken.
// Reset: rst_n clears every valid bit and holds busy high until the first edge after release.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module division_magic_constants_top
    import dmc_pkg::*;
#(
    parameter int unsigned STEPS = STEPS_PER_STAGE
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  operand,
    output logic      done,
    output out_word_t result
);

    // number of divider stages and total edges from accept to result
    localparam int unsigned NUM_STAGES = WORD_W / STEPS;
    localparam int unsigned LATENCY    = NUM_STAGES + 3;

    // busy while in reset and until ready_reg is set after release
    logic ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ready_reg <= 1'b0;
        else
            ready_reg <= 1'b1;
    end

    assign busy = ~ready_reg;

    logic accept;
    assign accept = start & ~busy;

    // front end: magnitude, leading-zero count, numerator high word and shifts
    logic      pipe_valid [NUM_STAGES+1];
    div_word_t pipe_word  [NUM_STAGES+1];

    dmc_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_word   (operand),
        .out_valid (pipe_valid[0]),
        .out_word  (pipe_word[0])
    );

    // quotient floor(high * 2^32 / den), STEPS bits per stage
    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_div
        dmc_div_stage #(
            .STEPS (STEPS)
        ) u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[g]),
            .in_word   (pipe_word[g]),
            .out_valid (pipe_valid[g+1]),
            .out_word  (pipe_word[g+1])
        );
    end

    // output register: multiplier is quotient plus one, zeros for a zero divisor
    div_word_t last_word;
    out_word_t result_next;
    out_word_t result_reg;
    logic      done_reg;

    assign last_word = pipe_word[NUM_STAGES];

    always_comb
    begin
        result_next.multiplier       = last_word.side.zero_divisor ? '0
                                     : last_word.quo + {{(WORD_W-1){1'b0}}, 1'b1};
        result_next.pre_shift        = last_word.side.pre_shift;
        result_next.post_shift       = last_word.side.post_shift;
        result_next.divisor_negative = last_word.side.divisor_negative;
        result_next.zero_divisor     = last_word.side.zero_divisor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= pipe_valid[NUM_STAGES];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // every accepted word produces a done strobe at the end of the pipeline
    a_accept_to_done : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted word did not produce a result");

    a_done_from_accept : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching accepted word");

    a_zero_clean : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.zero_divisor |-> result.multiplier == '0 && result.post_shift == '0
            && !result.pre_shift && !result.divisor_negative)
        else $error("zero divisor result carries non-zero fields");

    a_mode_fields : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.pre_shift |-> !result.divisor_negative)
        else $error("pre-shift and negative flag both set");

endmodule

/* test/division_magic_constants_checker.sv */
`timescale 1ns / 1ps

module division_magic_constants_checker
    import dmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  in_word_t    operand,
    input  logic        done,
    input  out_word_t   result,
    output int unsigned pending,
    output int unsigned failures
);

    out_word_t expected_constants[$];
    out_word_t want;

    // ceil(log2 x) for x >= 1: one past the top set bit of x - 1
    function automatic logic [LOG_W-1:0] ceil_log2(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] xm;
        logic [LOG_W-1:0]  n;
        xm = x - 1'b1;
        n  = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (xm[i])
                n = LOG_W'(i + 1);
        end
        return n;
    endfunction

    function automatic out_word_t predict_constants(input in_word_t w);
        out_word_t         r;
        logic [WORD_W-1:0] mag;
        logic [LOG_W-1:0]  lg;
        logic [63:0]       span;
        logic [63:0]       quot;
        r = '0;
        if (w.divisor == '0)
        begin
            r.zero_divisor = 1'b1;
        end
        else if (w.mode == MODE_UNSIGNED)
        begin
            lg   = ceil_log2(w.divisor);
            // 2^l - d, with l = 32 giving 2^32 - d in 64 bits
            span = (64'd1 << lg) - {32'd0, w.divisor};
            quot = (span << 32) / {32'd0, w.divisor} + 64'd1;
            r.multiplier = quot[WORD_W-1:0];
            r.pre_shift  = (lg != '0);
            r.post_shift = (lg != '0) ? SHIFT_W'(lg - 1'b1) : '0;
        end
        else
        begin
            r.divisor_negative = w.divisor[WORD_W-1];
            // 2^31 negates to itself, which is the magnitude wanted
            mag = w.divisor[WORD_W-1] ? (~w.divisor + 1'b1) : w.divisor;
            lg  = ceil_log2(mag);
            if (lg == '0)
                lg = LOG_W'(1);
            quot = (64'd1 << (31 + lg)) / {32'd0, mag} + 64'd1;
            r.multiplier = quot[WORD_W-1:0];
            r.post_shift = SHIFT_W'(lg - 1'b1);
        end
        return r;
    endfunction

    task automatic report(input string what, input out_word_t exp_w, input out_word_t got_w);
        if (failures < 10)
            $display("%0t %s: expected mult=%h pre=%0d post=%0d neg=%0d zero=%0d, got mult=%h pre=%0d post=%0d neg=%0d zero=%0d",
                     $realtime, what,
                     exp_w.multiplier, exp_w.pre_shift, exp_w.post_shift,
                     exp_w.divisor_negative, exp_w.zero_divisor,
                     got_w.multiplier, got_w.pre_shift, got_w.post_shift,
                     got_w.divisor_negative, got_w.zero_divisor);
        failures <= failures + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_constants.delete();
            pending  <= 0;
            failures <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_constants.push_back(predict_constants(operand));
            if (done === 1'b1)
            begin
                if (expected_constants.size() == 0)
                begin
                    report("result word with none outstanding", '0, result);
                end
                else
                begin
                    want = expected_constants.pop_front();
                    if (result.multiplier       !== want.multiplier
                     || result.pre_shift        !== want.pre_shift
                     || result.post_shift       !== want.post_shift
                     || result.divisor_negative !== want.divisor_negative
                     || result.zero_divisor     !== want.zero_divisor)
                        report("mismatch", want, result);
                end
            end
            pending <= expected_constants.size();
        end
    end

endmodule

/* test/division_magic_constants_top_tb.sv */
`timescale 1ns / 1ps

module division_magic_constants_top_tb;
    import dmc_pkg::*;

    // delay from the accepting edge to the result strobe, as in the design
    localparam int unsigned LATENCY    = WORD_W / STEPS_PER_STAGE + 3;
    // cycles without any word moving either way before the run is abandoned;
    // the longest legitimate lull is a sender idle gap plus the latency
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned PHASE_WORDS = 317;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    in_word_t  operand = '0;
    logic      done;
    out_word_t result;

    int unsigned outstanding;
    int unsigned failures;
    int unsigned quiet_cycles = 0;

    division_magic_constants_top DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operand (operand),
        .done    (done),
        .result  (result)
    );

    // the checker snoops both channels, predicts and keeps score
    division_magic_constants_checker constants_check
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operand  (operand),
        .done     (done),
        .result   (result),
        .pending  (outstanding),
        .failures (failures)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog: any accepted input word or any result strobe resets the count
    always @(posedge clk)
    begin
        if ((start && !busy) || done === 1'b1)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("division_magic_constants_top_tb NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic in_word_t make_word(input logic m, input logic [WORD_W-1:0] d);
        in_word_t w;
        w.mode    = m;
        w.divisor = d;
        return w;
    endfunction

    // Random divisor, biased towards the interesting regions: tiny values,
    // powers of two and their neighbours, the top of the range and the
    // signed boundary. Full-width patterns make sure every bit toggles.
    function automatic in_word_t random_word();
        logic [WORD_W-1:0] d;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: d = $urandom;
            4, 5:       d = $urandom_range(0, 300);
            6:          d = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 1;
            7:          d = 32'hFFFF_FFFF - $urandom_range(0, 300);
            8:          d = 32'h8000_0000 + $urandom_range(0, 600) - 300;
            default:    d = ~32'($urandom_range(0, 300)) + 1'b1;
        endcase
        return make_word(1'($urandom_range(0, 1)), d);
    endfunction

    // Present one word and hold it until the edge that takes it. Each cycle
    // the sender idles with chance idle_pct in a hundred; during an idle the
    // operand carries noise with start low. When the word is taken start
    // stays high, so a back-to-back word needs just one assignment in that
    // time step.
    task automatic send_word(input in_word_t w, input int unsigned idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start   <= 1'b0;
            operand <= random_word();
            @(posedge clk);
        end
        start   <= 1'b1;
        operand <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero divisor, unit divisors, the extremes of both readings
        // and the signed boundary, plus a few ordinary values
        send_word(make_word(MODE_UNSIGNED, 32'd0), 21);
        send_word(make_word(MODE_SIGNED,   32'd0), 21);
        send_word(make_word(MODE_UNSIGNED, 32'd1), 21);
        send_word(make_word(MODE_SIGNED,   32'd1), 21);
        send_word(make_word(MODE_SIGNED,   32'hFFFF_FFFF), 21);
        send_word(make_word(MODE_UNSIGNED, 32'd2), 21);
        send_word(make_word(MODE_UNSIGNED, 32'd3), 21);
        send_word(make_word(MODE_UNSIGNED, 32'd7), 21);
        send_word(make_word(MODE_UNSIGNED, 32'h7FFF_FFFF), 21);
        send_word(make_word(MODE_UNSIGNED, 32'h8000_0000), 21);
        send_word(make_word(MODE_UNSIGNED, 32'h8000_0001), 21);
        send_word(make_word(MODE_UNSIGNED, 32'hFFFF_FFFF), 21);
        send_word(make_word(MODE_SIGNED,   32'h8000_0000), 21);
        send_word(make_word(MODE_SIGNED,   32'h8000_0001), 21);
        send_word(make_word(MODE_SIGNED,   32'h7FFF_FFFF), 21);
        send_word(make_word(MODE_SIGNED,   32'd2), 21);
        send_word(make_word(MODE_SIGNED,   32'hFFFF_FFFE), 21);
        send_word(make_word(MODE_SIGNED,   32'd3), 21);
        send_word(make_word(MODE_SIGNED,   32'hFFFF_FFFD), 21);
        send_word(make_word(MODE_SIGNED,   32'd7), 21);
        send_word(make_word(MODE_UNSIGNED, 32'hAAAA_AAAA), 21);
        send_word(make_word(MODE_SIGNED,   32'h5555_5555), 21);
        send_word(make_word(MODE_UNSIGNED, 32'h0001_0000), 21);
        send_word(make_word(MODE_SIGNED,   32'hFFFF_0000), 21);

        // random: light sender idling, then heavy, then none
        for (int i = 0; i < PHASE_WORDS; i++)
            send_word(random_word(), 21);
        for (int i = 0; i < PHASE_WORDS; i++)
            send_word(random_word(), 47);
        for (int i = 0; i < PHASE_WORDS; i++)
            send_word(random_word(), 0);
        start <= 1'b0;

        // the outstanding count is a registered copy of the checker's queue size
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        // let any stray strobe show up
        repeat (2 * LATENCY) @(posedge clk);

        if (failures == 0)
            $display("division_magic_constants_top_tb OK");
        else
            $display("division_magic_constants_top_tb NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dmc_pkg.sv
rtl/dmc_prep.sv
rtl/dmc_div_stage.sv
rtl/division_magic_constants_top.sv
test/division_magic_constants_checker.sv
test/division_magic_constants_top_tb.sv
